### rtl/ldr_pkg.sv
// Shared constants, types and arithmetic helpers for the reflection core.
package ldr_pkg;

  // Default configuration of the core.
  localparam int unsigned DefOrder      = 10;
  localparam int unsigned DefSampleBits = 16;

  // Fixed widths of the item fields and internal number formats.
  localparam int unsigned SampleW = 16;
  localparam int unsigned ReflW   = 16;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned LagW    = 48;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned QFrac   = 27;

  // Saturation bounds of the lag accumulators.
  localparam logic signed [LagW-1:0] LagMax = {1'b0, {(LagW-1){1'b1}}};
  localparam logic signed [LagW-1:0] LagMin = {1'b1, {(LagW-1){1'b0}}};

  // One input item as it travels from the front part to the back part.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
  } ldr_item_t;

  // Saturate a 64-bit value to the signed 32-bit range.
  function automatic logic signed [CoefW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[CoefW-1:0];
    end
  endfunction

endpackage

### rtl/levinson_durbin_reflection_core.sv
// Top level of the LPC reflection-coefficient core.
//
// Input channel: push/full carry one sample item, with block_end_i set on
// the final sample of an analysis block. Output channel: empty/pop give
// one reflection item per coefficient, ORDER items per block, the last one
// flagged by last_coef_o.
// Each sample passes through the shared multiply-accumulate unit, which
// updates the lags one after the other. After the block end, normalizing
// the lags takes ORDER divisions, and each recursion step takes one division
// plus its multiply steps; the divider is a bit-serial restoring divider.
// A two-item queue decouples the input side, so samples are taken while the
// back part is busy. A result waits in the output register while the
// receiver stalls, and the recursion pauses until it is popped.
// Reset clears the delay line, the lag sums, the queue and the result
// register; the block takes an item in the first cycle after reset.
module levinson_durbin_reflection_core import ldr_pkg::*; #(
  parameter int unsigned Order      = DefOrder,
  parameter int unsigned SampleBits = DefSampleBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                     block_end_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [ReflW-1:0]  reflection_o,
  output logic [IdxW-1:0]          coef_index_o,
  output logic                     last_coef_o
);

  logic      q_valid;
  logic      q_take;
  ldr_item_t q_item;

  ldr_front #(.SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .sample_i, .block_end_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_item_o(q_item)
  );

  ldr_back #(.Order(Order)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_take_o(q_take), .q_item_i(q_item),
    .empty_o(empty), .pop_i(pop),
    .reflection_o, .coef_index_o, .last_coef_o
  );

endmodule

### rtl/ldr_front.sv
// Front part: sign-adjusts input items and feeds a short queue to the back part.
module ldr_front import ldr_pkg::*; #(
  parameter int unsigned SampleBits = DefSampleBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      block_end_i,
  output logic                      q_valid_o,
  input  logic                      q_take_i,
  output ldr_item_t                 q_item_o
);

  localparam int unsigned Depth = 2;

  ldr_item_t  mem_q [Depth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  ldr_item_t  in_item;

  // Keep only the low SampleBits of the sample, sign-extended.
  always_comb begin
    in_item.sample    = SampleW'($signed(sample_i[SampleBits-1:0]));
    in_item.block_end = block_end_i;
  end

  assign full_o    = (cnt_q == 2'(Depth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_take_i && q_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= in_item;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(Depth))
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o)
    else $error("queue lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_valid_o && !do_push) |=> !q_valid_o)
    else $error("queue invented an item");

endmodule

### rtl/ldr_back.sv
// Back part: lag accumulation, recursion sequencer, divider and result register.
module ldr_back import ldr_pkg::*; #(
  parameter int unsigned Order = DefOrder
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_take_o,
  input  ldr_item_t                q_item_i,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic signed [ReflW-1:0]  reflection_o,
  output logic [IdxW-1:0]          coef_index_o,
  output logic                     last_coef_o
);

  localparam int unsigned LW = $clog2(Order + 1);
  localparam int unsigned HW = (Order > 1) ? $clog2(Order) : 1;

  typedef enum logic [3:0] {
    SIdle, SLag, SRdiv, SRdivRun, SInit, SErr, SNumDiv, SDivRun,
    SUpd, SUpdW, SEnergy, SEnergyW, SOut, SZero, SClear
  } state_e;

  state_e state_q;

  // Lag and predictor storage.
  logic signed [SampleW-1:0] hist_q [Order];
  logic signed [LagW-1:0]    lag_q  [Order+1];
  logic signed [CoefW-1:0]   r_q    [Order+1];
  logic signed [CoefW-1:0]   a_q    [Order+1];
  logic signed [CoefW-1:0]   an_q   [Order+1];
  logic [31:0]               e_q;

  logic [LW-1:0]             k_q;
  logic [LW-1:0]             m_q;
  logic signed [SampleW-1:0] x_q;
  logic                      end_q;
  logic signed [63:0]        acc_q;
  logic signed [63:0]        prod_q;
  logic                      prod_v_q;
  logic signed [CoefW-1:0]   km_q;

  // Restoring divider.
  logic [47:0] dn_q;
  logic [47:0] dd_q;
  logic [48:0] rem_q;
  logic [31:0] qt_q;
  logic [31:0] lim_q;
  logic [6:0]  dcnt_q;
  logic [6:0]  dlen_q;
  logic        dneg_q;
  logic        dsat_q;
  logic [48:0] rem_sh;
  logic [48:0] rem_sub;
  logic [32:0] q_nx;
  logic [31:0] q_res;
  logic        ge;

  // Result register.
  logic                    out_v_q;
  logic signed [ReflW-1:0] out_r_q;
  logic [IdxW-1:0]         out_i_q;
  logic                    out_l_q;

  assign empty_o      = !out_v_q;
  assign reflection_o = out_r_q;
  assign coef_index_o = out_i_q;
  assign last_coef_o  = out_l_q;
  assign q_take_o     = (state_q == SIdle) && q_valid_i;

  // One divider step; the quotient is capped at the limit on the final step too.
  always_comb begin
    rem_sh  = {rem_q[47:0], (dcnt_q < 7'd48) ? dn_q[47] : 1'b0};
    ge      = rem_sh >= {1'b0, dd_q};
    rem_sub = ge ? rem_sh - {1'b0, dd_q} : rem_sh;
    q_nx    = {qt_q, ge};
    q_res   = dsat_q ? qt_q : ((q_nx > {1'b0, lim_q}) ? lim_q : q_nx[31:0]);
  end

  // Helper views for the recursion step.
  logic [LW-1:0] mk;
  logic signed [63:0] sx_sq, lag_add, lag_sum;
  logic [63:0] km_mag, km2;
  logic [31:0] tq;
  logic signed [63:0] num64, refl64;
  always_comb begin
    mk      = m_q - k_q;
    lag_add = (k_q == '0) ? 64'(x_q) * 64'(x_q)
                          : 64'(x_q) * 64'(hist_q[HW'(k_q - 1'b1)]);
    lag_sum = 64'(lag_q[k_q]) + prod_q;
    sx_sq   = 64'(LagMax);
    km_mag  = km_q[31] ? 64'(-64'(km_q)) : 64'(km_q);
    km2     = 64'(prod_q) >> QFrac;
    tq      = (km2 >= 64'(1 << QFrac)) ? 32'd0 : 32'((64'(1 << QFrac)) - km2);
    num64   = 64'(r_q[m_q]) - acc_q;
    refl64  = (-64'(km_q)) >>> 12;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      out_v_q  <= 1'b0;
      k_q      <= '0;
      m_q      <= '0;
      prod_v_q <= 1'b0;
      for (int i = 0; i < Order; i++) hist_q[i] <= '0;
      for (int i = 0; i <= Order; i++) lag_q[i] <= '0;
      e_q      <= '0;
    end else begin
      // The emitting states load the result register themselves.
      if (pop_i && out_v_q && state_q != SOut && state_q != SZero) out_v_q <= 1'b0;
      case (state_q)
        // Take one item from the queue.
        SIdle: begin
          if (q_valid_i) begin
            x_q      <= q_item_i.sample;
            end_q    <= q_item_i.block_end;
            k_q      <= '0;
            prod_v_q <= 1'b0;
            state_q  <= SLag;
          end
        end
        // One shared multiply-accumulate per lag.
        SLag: begin
          if (!prod_v_q) begin
            prod_q   <= lag_add;
            prod_v_q <= 1'b1;
          end else begin
            prod_v_q <= 1'b0;
            if (lag_sum > sx_sq) lag_q[k_q] <= LagMax;
            else if (lag_sum < 64'(LagMin)) lag_q[k_q] <= LagMin;
            else lag_q[k_q] <= lag_sum[LagW-1:0];
            if (k_q == LW'(Order)) begin
              for (int i = Order - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
              hist_q[0] <= x_q;
              if (!end_q) state_q <= SIdle;
              else begin
                m_q     <= '0;
                state_q <= SRdiv;
              end
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        // Normalize lags: r[k] = lag[k] / lag[0] in Q1.31.
        SRdiv: begin
          if (lag_q[0] <= '0) begin
            m_q     <= LW'(1);
            state_q <= SZero;
          end else if (m_q == LW'(Order)) begin
            m_q     <= LW'(1);
            state_q <= SInit;
          end else begin
            dn_q    <= lag_q[m_q+1'b1][47] ? 48'(-lag_q[m_q+1'b1])
                                          : 48'(lag_q[m_q+1'b1]);
            dneg_q  <= lag_q[m_q+1'b1][47];
            lim_q   <= lag_q[m_q+1'b1][47] ? 32'h80000000 : 32'h7fffffff;
            dd_q    <= 48'(lag_q[0]);
            dlen_q  <= 7'd78;
            rem_q   <= '0;
            qt_q    <= '0;
            dcnt_q  <= '0;
            dsat_q  <= 1'b0;
            state_q <= SRdivRun;
          end
        end
        SRdivRun, SDivRun: begin
          if (!dsat_q) begin
            rem_q <= rem_sub;
            dn_q  <= {dn_q[46:0], 1'b0};
            if (q_nx > {1'b0, lim_q}) begin
              qt_q <= lim_q; dsat_q <= 1'b1;
            end else qt_q <= q_nx[31:0];
          end
          if (dsat_q || dcnt_q == dlen_q) begin
            if (state_q == SRdivRun) begin
              r_q[m_q+1'b1] <= dneg_q ? -$signed(q_res) : $signed(q_res);
              m_q     <= m_q + 1'b1;
              state_q <= SRdiv;
            end else begin
              km_q    <= dneg_q ? -$signed(q_res) : $signed(q_res);
              k_q     <= LW'(1);
              prod_v_q<= 1'b0;
              state_q <= SUpd;
            end
          end
          dcnt_q <= dcnt_q + 1'b1;
        end
        // Start the recursion.
        SInit: begin
          for (int i = 0; i <= Order; i++) a_q[i] <= '0;
          a_q[0]   <= 32'sd1 <<< QFrac;
          e_q      <= 32'h80000000;
          acc_q    <= '0;
          k_q      <= LW'(1);
          prod_v_q <= 1'b0;
          state_q  <= SErr;
        end
        // err = sum a[k]*r[m-k] >> 27.
        SErr: begin
          if (k_q >= m_q) begin
            dn_q    <= num64[63] ? 48'(-num64) : 48'(num64);
            dneg_q  <= num64[63];
            lim_q   <= num64[63] ? 32'h80000000 : 32'h7fffffff;
            dd_q    <= 48'(e_q);
            dlen_q  <= 7'd74;
            rem_q   <= '0;
            qt_q    <= '0;
            dcnt_q  <= '0;
            dsat_q  <= 1'b0;
            state_q <= SDivRun;
          end else if (!prod_v_q) begin
            prod_q   <= 64'(a_q[k_q]) * 64'(r_q[mk]);
            prod_v_q <= 1'b1;
          end else begin
            acc_q    <= acc_q + (prod_q >>> QFrac);
            prod_v_q <= 1'b0;
            k_q      <= k_q + 1'b1;
          end
        end
        // a'[k] = a[k] - km*a[m-k] >> 27.
        SUpd: begin
          if (k_q >= m_q) begin
            an_q[m_q] <= km_q;
            prod_q    <= 64'(km_mag) * 64'(km_mag);
            state_q   <= SEnergy;
          end else if (!prod_v_q) begin
            prod_q   <= 64'(km_q) * 64'(a_q[mk]);
            prod_v_q <= 1'b1;
          end else begin
            an_q[k_q] <= sat32(64'(a_q[k_q]) - (prod_q >>> QFrac));
            prod_v_q  <= 1'b0;
            k_q       <= k_q + 1'b1;
          end
        end
        SEnergy: begin
          prod_q  <= 64'(e_q) * 64'(tq);
          state_q <= SEnergyW;
        end
        SEnergyW: begin
          e_q <= 32'(64'(prod_q) >> QFrac);
          for (int i = 1; i <= Order; i++) if (i <= m_q) a_q[i] <= an_q[i];
          state_q <= SOut;
        end
        // Emit one coefficient.
        SOut: begin
          if (!out_v_q || pop_i) begin
            out_v_q <= 1'b1;
            out_r_q <= (refl64 > 64'sd32767) ? 16'sh7fff :
                       (refl64 < -64'sd32768) ? 16'sh8000 : refl64[15:0];
            out_i_q <= IdxW'(m_q - 1'b1);
            out_l_q <= (m_q == LW'(Order));
            if (m_q == LW'(Order)) state_q <= SClear;
            else begin
              m_q      <= m_q + 1'b1;
              acc_q    <= '0;
              k_q      <= LW'(1);
              prod_v_q <= 1'b0;
              state_q  <= SErr;
            end
          end
        end
        // Zero energy: all coefficients zero.
        SZero: begin
          if (!out_v_q || pop_i) begin
            out_v_q <= 1'b1;
            out_r_q <= '0;
            out_i_q <= IdxW'(m_q - 1'b1);
            out_l_q <= (m_q == LW'(Order));
            if (m_q == LW'(Order)) state_q <= SClear;
            else m_q <= m_q + 1'b1;
          end
        end
        SClear: begin
          for (int i = 0; i < Order; i++) hist_q[i] <= '0;
          for (int i = 0; i <= Order; i++) lag_q[i] <= '0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |=> out_v_q && $stable(out_r_q))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take_o |-> state_q == SIdle)
    else $error("item taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClear) |-> out_l_q)
    else $error("block ended without last coefficient");

endmodule

### sim/levinson_durbin_reflection_core_test.sv
// Testbench for the LPC reflection-coefficient core: directed and random sample blocks.
module levinson_durbin_reflection_core_test import ldr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCoef = DefOrder;
  localparam longint LagHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint LagLo = -LagHi - 1;
  localparam longint OneQ27 = 64'sd1 << QFrac;

  // One expected reflection item.
  typedef struct {
    logic signed [ReflW-1:0] refl;
    logic [IdxW-1:0]         idx;
    logic                    last;
  } refl_item_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic signed [SampleW-1:0] sample_i;
  logic                      block_end_i;
  logic                      empty;
  logic                      pop;
  logic signed [ReflW-1:0]   reflection_o;
  logic [IdxW-1:0]           coef_index_o;
  logic                      last_coef_o;

  // Predictor state: delay line and lag sums of the block in progress.
  longint     delay_line[NumCoef];
  longint     lag_acc[NumCoef+1];
  refl_item_t pending_refl[$];
  int         mismatches;
  int         hold_off_cycles;
  bit         no_idle;

  levinson_durbin_reflection_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_i     (sample_i),
    .block_end_i  (block_end_i),
    .empty        (empty),
    .pop          (pop),
    .reflection_o (reflection_o),
    .coef_index_o (coef_index_o),
    .last_coef_o  (last_coef_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Bit-serial restoring division: floor(n * 2^fb / d), capped at cap.
  function automatic longint unsigned restoring_div(longint unsigned n, longint unsigned d,
                                                    int fb, longint unsigned cap);
    longint unsigned rem;
    longint unsigned q;
    longint unsigned b;
    rem = 0;
    q = 0;
    for (int i = 0; i < 48 + fb; i++) begin
      b = (i < 48) ? ((n >> (47 - i)) & 64'd1) : 64'd0;
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  // Signed division saturating to the 32-bit range with the sign of n.
  function automatic longint signed_div(longint n, longint unsigned d, int fb);
    if (n < 0) return -longint'(restoring_div(longint'(-n), d, fb, 64'd1 << 31));
    return longint'(restoring_div(n, d, fb, (64'd1 << 31) - 1));
  endfunction

  // Run the fixed-point recursion on the finished block and queue its coefficients.
  task automatic predict_reflections();
    longint r[NumCoef+1];
    longint a_prev[NumCoef+1];
    longint a_next[NumCoef+1];
    longint unsigned energy;
    longint unsigned km_sq;
    longint unsigned shrink;
    longint acc;
    longint num;
    longint km;
    refl_item_t item;
    for (int m = 1; m <= NumCoef; m++) begin
      item.refl = '0;
      item.idx = IdxW'(m - 1);
      item.last = (m == NumCoef);
      pending_refl.push_back(item);
    end
    if (lag_acc[0] > 0) begin
      // Normalize the lags by lag zero, then step the recursion up one order at a time.
      for (int k = 1; k <= NumCoef; k++) r[k] = signed_div(lag_acc[k], lag_acc[0], 31);
      for (int k = 0; k <= NumCoef; k++) a_prev[k] = 0;
      a_prev[0] = OneQ27;
      energy = 64'd1 << 31;
      for (int m = 1; m <= NumCoef; m++) begin
        acc = 0;
        for (int k = 1; k < m; k++) acc += (a_prev[k] * r[m-k]) >>> QFrac;
        num = r[m] - acc;
        km = signed_div(num, energy, QFrac);
        pending_refl[pending_refl.size() - NumCoef + m - 1].refl =
          ReflW'(clamp((-km) >>> 12, -32768, 32767));
        a_next = a_prev;
        a_next[m] = km;
        for (int k = 1; k < m; k++)
          a_next[k] = clamp(a_prev[k] - ((km * a_prev[m-k]) >>> QFrac),
                            -64'sd2147483648, 64'sd2147483647);
        km_sq = longint'((km < 0 ? -km : km) * (km < 0 ? -km : km)) >> QFrac;
        shrink = (km_sq >= OneQ27) ? 64'd0 : OneQ27 - km_sq;
        energy = (energy * shrink) >> QFrac;
        a_prev = a_next;
      end
    end
    for (int k = 0; k < NumCoef; k++) delay_line[k] = 0;
    for (int k = 0; k <= NumCoef; k++) lag_acc[k] = 0;
  endtask

  // Accumulate one accepted sample into the lags; finish the block on its end.
  task automatic predict_sample(logic signed [SampleW-1:0] s, logic fin);
    longint x;
    x = s;
    lag_acc[0] = clamp(lag_acc[0] + x * x, LagLo, LagHi);
    for (int k = 1; k <= NumCoef; k++)
      lag_acc[k] = clamp(lag_acc[k] + x * delay_line[k-1], LagLo, LagHi);
    for (int k = NumCoef - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = x;
    if (fin) predict_reflections();
  endtask

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (no_idle || pick < 11) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one item, wait until it is taken, then idle for a random gap.
  task automatic send_sample(logic signed [SampleW-1:0] s, logic fin);
    int gap;
    push = 1'b1;
    sample_i = s;
    block_end_i = fin;
    do @(posedge clk_i); while (full);
    predict_sample(s, fin);
    @(negedge clk_i);
    // Withdraw the offer; a following item raises push again at this same edge.
    push = 1'b0;
    gap = idle_len();
    if (gap > 0) begin
      sample_i = SampleW'($urandom);
      block_end_i = $urandom_range(0, 1);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_refl.size() != 0) @(negedge clk_i);
  endtask

  // Extreme single samples, an all-zero block, a constant block and an alternating one.
  task automatic test_directed_edges();
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    repeat (2) send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    repeat (7) send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? -16'sh8000 : 16'sh7fff, i == 7);
    wait_drained();
  endtask

  // Random blocks of mixed character: white noise, low level, zeros with random spikes, correlated walks.
  task automatic test_random_blocks(int n_items);
    int sent;
    int len;
    int kind;
    int walk;
    logic signed [SampleW-1:0] s;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      kind = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      walk = $signed(16'($urandom));
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: s = SampleW'($urandom);
          1: s = SampleW'($signed(8'($urandom)));
          2: s = 16'sh0000;
          default: begin
            walk = int'(clamp(walk + $signed(12'($urandom)), -32768, 32767));
            s = SampleW'(walk);
          end
        endcase
        if (kind == 2 && $urandom_range(0, 1)) s = SampleW'($urandom);
        send_sample(s, i == len - 1);
      end
      sent += len;
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // The receiver holds off while samples keep coming, so the input queue fills.
  task automatic test_backpressure();
    hold_off_cycles = 900;
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) send_sample(SampleW'($urandom), i == 4 || i == 29);
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Receiver side: random pops, with a long hold-off when one is requested.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        pop = 1'b0;
        hold_off_cycles--;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        pop = 1'b0;
        repeat (idle_len()) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Compare each popped item with the oldest expected coefficient.
  always @(posedge clk_i) begin
    refl_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_refl.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: refl=%0d idx=%0d last=%0b",
                   reflection_o, coef_index_o, last_coef_o);
      end else begin
        want = pending_refl.pop_front();
        if (reflection_o !== want.refl || coef_index_o !== want.idx
            || last_coef_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected refl=%0d idx=%0d last=%0b, got %0d %0d %0b",
                     want.refl, want.idx, want.last,
                     reflection_o, coef_index_o, last_coef_o);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    mismatches = 0;
    hold_off_cycles = 0;
    no_idle = 1'b0;
    push = 1'b0;
    sample_i = '0;
    block_end_i = 1'b0;
    for (int k = 0; k < NumCoef; k++) delay_line[k] = 0;
    for (int k = 0; k <= NumCoef; k++) lag_acc[k] = 0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_edges();
    test_backpressure();
    test_random_blocks(270);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_refl.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
